### sv/rtfus_pkg.sv
// rtfus_pkg: shared types, widths and calendar constants for the RTC-to-Unix-seconds pipeline.
// No dependencies; the top level, rtfus_decode, rtfus_date and rtfus_secs use it.
package rtfus_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DAYS_W = 17;
    localparam int unsigned HMS_W  = 20;
    localparam int unsigned SECS_W = 33;

    localparam logic [BYTE_W-1:0] YEAR_PIVOT   = 8'd70;
    localparam logic [BYTE_W-1:0] OFF_20XX     = 8'd30;
    localparam logic [BYTE_W-1:0] OFF_19XX     = 8'd70;
    localparam logic [BYTE_W-1:0] OFF_Y2100    = 8'd130;
    localparam logic [1:0]        LEAP_PHASE   = 2'd2;
    localparam logic [BYTE_W-1:0] MONTH_MAX    = 8'd12;
    localparam logic [BYTE_W-1:0] DATE_MAX     = 8'd31;
    localparam logic [BYTE_W-1:0] FEB          = 8'd2;
    localparam logic [DAYS_W-1:0] DAYS_PER_YR  = 17'd365;
    localparam logic [HMS_W-1:0]  SECS_PER_HR  = 20'd3600;
    localparam logic [HMS_W-1:0]  SECS_PER_MIN = 20'd60;
    localparam logic [SECS_W-1:0] SECS_PER_DAY = 33'd86400;

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic [BYTE_W-1:0] yr;
        logic [BYTE_W-1:0] mon;
        logic [BYTE_W-1:0] dt;
        logic [BYTE_W-1:0] hr;
        logic [BYTE_W-1:0] mi;
        logic [BYTE_W-1:0] se;
    } dec_beat_t;

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic [DAYS_W-1:0] days;
        logic [HMS_W-1:0]  hms;
    } day_beat_t;

    // BCD byte decoded as 10*high+low, no digit check; the raw byte is returned when bin is set
    function automatic logic [BYTE_W-1:0] dec_byte(input logic [BYTE_W-1:0] raw,
                                                   input logic bin);
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        hi = {4'b0, raw[7:4]};
        lo = {4'b0, raw[3:0]};
        if (bin)
            return raw;
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // days before the first of the month, month 1..12
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/rtc_fields_to_unix_seconds_top.sv
// rtc_fields_to_unix_seconds_top: RTC register bytes to 33-bit Unix seconds.
// Pipeline stages, start beat to done strobe: decode, day count, multiply, add.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Reset: async active low clears all valid bits and binary_mode (BCD).
// Depends on rtfus_pkg, rtfus_decode, rtfus_date, rtfus_secs.
module rtc_fields_to_unix_seconds_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  year_raw,
    input  logic [7:0]  month_raw,
    input  logic [7:0]  date_raw,
    input  logic [7:0]  hour_raw,
    input  logic [7:0]  minute_raw,
    input  logic [7:0]  second_raw,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        done,
    output logic [32:0] unix_seconds,
    output logic        bad_date
);

    logic                 binary_mode_reg;
    rtfus_pkg::dec_beat_t dec_beat;
    rtfus_pkg::day_beat_t day_beat;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            binary_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            binary_mode_reg <= cfg_data;
    end

    rtfus_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .binary_mode (binary_mode_reg),
        .year_raw    (year_raw),
        .month_raw   (month_raw),
        .date_raw    (date_raw),
        .hour_raw    (hour_raw),
        .minute_raw  (minute_raw),
        .second_raw  (second_raw),
        .dec_out     (dec_beat)
    );

    rtfus_date u_date (
        .clk     (clk),
        .rst_n   (rst_n),
        .dec_in  (dec_beat),
        .day_out (day_beat)
    );

    rtfus_secs u_secs (
        .clk          (clk),
        .rst_n        (rst_n),
        .day_in       (day_beat),
        .done         (done),
        .unix_seconds (unix_seconds),
        .bad_date     (bad_date)
    );

endmodule

### sv/rtfus_decode.sv
// rtfus_decode: stage 1, BCD/binary byte decode and month/date range check.
// Depends on rtfus_pkg.
module rtfus_decode (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     binary_mode,
    input  logic [7:0]               year_raw,
    input  logic [7:0]               month_raw,
    input  logic [7:0]               date_raw,
    input  logic [7:0]               hour_raw,
    input  logic [7:0]               minute_raw,
    input  logic [7:0]               second_raw,
    output rtfus_pkg::dec_beat_t     dec_out
);

    rtfus_pkg::dec_beat_t dec_next;
    rtfus_pkg::dec_beat_t dec_reg;
    logic                 valid_reg;

    always_comb
    begin
        dec_next.valid = in_valid;
        dec_next.yr    = rtfus_pkg::dec_byte(year_raw,   binary_mode);
        dec_next.mon   = rtfus_pkg::dec_byte(month_raw,  binary_mode);
        dec_next.dt    = rtfus_pkg::dec_byte(date_raw,   binary_mode);
        dec_next.hr    = rtfus_pkg::dec_byte(hour_raw,   binary_mode);
        dec_next.mi    = rtfus_pkg::dec_byte(minute_raw, binary_mode);
        dec_next.se    = rtfus_pkg::dec_byte(second_raw, binary_mode);
        dec_next.bad   = (dec_next.mon == 8'd0) || (dec_next.mon > rtfus_pkg::MONTH_MAX)
                      || (dec_next.dt == 8'd0) || (dec_next.dt > rtfus_pkg::DATE_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= dec_next.valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    always_comb
    begin
        dec_out       = dec_reg;
        dec_out.valid = valid_reg;
    end

endmodule

### sv/rtfus_date.sv
// rtfus_date: stage 2, day count since 1970-01-01 and time-of-day seconds.
// Depends on rtfus_pkg.
module rtfus_date (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtfus_pkg::dec_beat_t  dec_in,
    output rtfus_pkg::day_beat_t  day_out
);

    logic [7:0]  off;
    logic [8:0]  off_p1;
    logic [5:0]  leaps;
    logic        past_2100;
    logic        leap_yr;
    logic        leap_adj;
    logic [16:0] year_days;
    logic [7:0]  dt_m1;

    rtfus_pkg::day_beat_t day_next;
    rtfus_pkg::day_beat_t day_reg;
    logic                 valid_reg;

    always_comb
    begin
        if (dec_in.yr < rtfus_pkg::YEAR_PIVOT)
            off = dec_in.yr + rtfus_pkg::OFF_20XX;
        else
            off = dec_in.yr - rtfus_pkg::OFF_19XX;
        off_p1    = {1'b0, off} + 9'd1;
        past_2100 = off > rtfus_pkg::OFF_Y2100;
        // leap years in 1970..year-1; 2000 counts, 2100 does not
        leaps     = off_p1[7:2] - {5'b0, past_2100};
        leap_yr   = (off[1:0] == rtfus_pkg::LEAP_PHASE) && (off != rtfus_pkg::OFF_Y2100);
        leap_adj  = leap_yr && (dec_in.mon > rtfus_pkg::FEB);
        year_days = {9'b0, off} * rtfus_pkg::DAYS_PER_YR + {11'b0, leaps};
        dt_m1     = dec_in.dt - 8'd1;

        day_next.valid = dec_in.valid;
        day_next.bad   = dec_in.bad;
        day_next.days  = year_days
                       + {8'b0, rtfus_pkg::month_start(dec_in.mon[3:0])}
                       + {9'b0, dt_m1}
                       + {16'b0, leap_adj};
        day_next.hms   = {12'b0, dec_in.hr} * rtfus_pkg::SECS_PER_HR
                       + {12'b0, dec_in.mi} * rtfus_pkg::SECS_PER_MIN
                       + {12'b0, dec_in.se};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= day_next.valid;
    end

    always_ff @(posedge clk)
    begin
        day_reg <= day_next;
    end

    always_comb
    begin
        day_out       = day_reg;
        day_out.valid = valid_reg;
    end

endmodule

### sv/rtfus_secs.sv
// rtfus_secs: stages 3 and 4, days times 86400, then add time of day into the result register (zero for a bad date).
// Depends on rtfus_pkg.
module rtfus_secs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtfus_pkg::day_beat_t  day_in,
    output logic                  done,
    output logic [32:0]           unix_seconds,
    output logic                  bad_date
);

    logic        s3_valid_reg;
    logic        s3_bad_reg;
    logic [32:0] s3_prod_reg;
    logic [32:0] s3_prod_next;
    logic [19:0] s3_hms_reg;

    logic        done_reg;
    logic        bad_date_reg;
    logic [32:0] secs_reg;
    logic [32:0] secs_next;

    assign s3_prod_next = {16'b0, day_in.days} * rtfus_pkg::SECS_PER_DAY;
    assign secs_next    = s3_bad_reg ? 33'd0 : s3_prod_reg + {13'b0, s3_hms_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= day_in.valid;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_bad_reg   <= day_in.bad;
        s3_prod_reg  <= s3_prod_next;
        s3_hms_reg   <= day_in.hms;
        bad_date_reg <= s3_bad_reg;
        secs_reg     <= secs_next;
    end

    assign done         = done_reg;
    assign unix_seconds = secs_reg;
    assign bad_date     = bad_date_reg;

endmodule

### sv/rtfus_checker.sv
// rtfus_checker: port-level assertions for rtc_fields_to_unix_seconds_top, and its bind.
// Depends on the top level's ports only.
module rtfus_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        done,
    input logic [32:0] unix_seconds,
    input logic        bad_date
);

    // every accepted beat yields exactly one done strobe, and no strobe comes without an accepted beat
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4))
        |-> (done == $past(start && !busy, 4)))
        else $error("done does not match accepted beat four cycles back");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_date) |-> (unix_seconds == 33'd0))
        else $error("bad date result with nonzero seconds");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("start refused");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write held off");

endmodule

bind rtc_fields_to_unix_seconds_top rtfus_checker u_rtfus_checker (.*);

### verif/tb_rtc_fields_to_unix_seconds_top.sv
// tb_rtc_fields_to_unix_seconds_top: self-checking bench for the RTC-to-Unix-seconds block.
// Directed calendar edge cases, then random BCD and binary dates under sender idle phases;
// a scoreboard class predicts each conversion. Depends on rtfus_pkg and the block's RTL.
module tb_rtc_fields_to_unix_seconds_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] yr;
        logic [7:0] mon;
        logic [7:0] dt;
        logic [7:0] hr;
        logic [7:0] mi;
        logic [7:0] se;
    } rtc_bytes_t;

    class unix_time_scoreboard;
        localparam int unsigned EPOCH = 1970;
        localparam int unsigned CENTURY_20 = 2000;
        localparam int unsigned CENTURY_19 = 1900;
        localparam int unsigned PIVOT = 70;

        typedef struct packed {
            logic [rtfus_pkg::SECS_W-1:0] secs;
            logic                         bad;
        } unix_result_t;

        logic           binary;
        int             errors;
        unix_result_t   pending_q[$];
        int unsigned    month_offset[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

        function new();
            binary = 1'b0;
            errors = 0;
        endfunction

        function int unsigned decode(logic [7:0] raw);
            if (binary)
                return raw;
            return 10 * raw[7:4] + raw[3:0];
        endfunction

        function int unsigned leaps_upto(int unsigned n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        function unix_result_t convert(rtc_bytes_t b);
            unix_result_t      r;
            int unsigned       yr;
            int unsigned       mon;
            int unsigned       dt;
            int unsigned       year;
            longint unsigned   days;
            longint unsigned   secs;
            yr = decode(b.yr);
            mon = decode(b.mon);
            dt = decode(b.dt);
            if (mon < 1 || mon > 12 || dt < 1 || dt > 31)
            begin
                r.secs = '0;
                r.bad = 1'b1;
                return r;
            end
            year = (yr < PIVOT) ? yr + CENTURY_20 : yr + CENTURY_19;
            days = longint'(365) * (year - EPOCH) + (leaps_upto(year - 1) - leaps_upto(EPOCH - 1))
                 + month_offset[mon - 1] + (dt - 1);
            if (mon > 2 && leap_year(year))
                days++;
            secs = days * 86400 + longint'(decode(b.hr)) * 3600 + decode(b.mi) * 60
                 + decode(b.se);
            r.secs = secs[rtfus_pkg::SECS_W-1:0];
            r.bad = 1'b0;
            return r;
        endfunction

        function void note_item(rtc_bytes_t b);
            pending_q.push_back(convert(b));
        endfunction

        function void check_result(logic [rtfus_pkg::SECS_W-1:0] secs, logic bad);
            unix_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected beat, unix_seconds %0d bad_date %0b", $time, secs, bad);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (exp_r.secs !== secs)
            begin
                $display("%0t: unix_seconds expected %0d actual %0d", $time, exp_r.secs, secs);
                errors++;
            end
            if (exp_r.bad !== bad)
            begin
                $display("%0t: bad_date expected %0b actual %0b", $time, exp_r.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [7:0]                   year_raw;
    logic [7:0]                   month_raw;
    logic [7:0]                   date_raw;
    logic [7:0]                   hour_raw;
    logic [7:0]                   minute_raw;
    logic [7:0]                   second_raw;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_data;
    logic                         done;
    logic [rtfus_pkg::SECS_W-1:0] unix_seconds;
    logic                         bad_date;

    unix_time_scoreboard sb = new();
    int cycles = 0;

    int   phase_pct[6]   = '{0, 62, 10, 62, 10, 0};
    logic phase_mode[6]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    int   phase_items[6] = '{250, 200, 250, 200, 200, 150};

    rtc_fields_to_unix_seconds_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .year_raw     (year_raw),
        .month_raw    (month_raw),
        .date_raw     (date_raw),
        .hour_raw     (hour_raw),
        .minute_raw   (minute_raw),
        .second_raw   (second_raw),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .unix_seconds (unix_seconds),
        .bad_date     (bad_date)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.binary = cfg_data;
            if (start && !busy)
                sb.note_item({year_raw, month_raw, date_raw, hour_raw, minute_raw, second_raw});
            if (done)
                sb.check_result(unix_seconds, bad_date);
        end
    end

    task automatic send_item(input rtc_bytes_t b);
        start <= 1'b1;
        {year_raw, month_raw, date_raw, hour_raw, minute_raw, second_raw} <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int pct);
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            {year_raw, month_raw, date_raw, hour_raw, minute_raw, second_raw}
                <= 48'({$urandom, $urandom});
            @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic binary);
        cfg_valid <= 1'b1;
        cfg_data <= binary;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] encode(input int unsigned v, input logic binary);
        if (binary)
            return 8'(v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic rtc_bytes_t random_item(input logic binary);
        rtc_bytes_t b;
        int         kind;
        kind = $urandom_range(0, 99);
        b = 48'({$urandom, $urandom});
        if (kind < 12)
            return b;
        b.mon = encode($urandom_range(1, 12), binary);
        b.dt = encode($urandom_range(1, 31), binary);
        if (kind < 20)
            return b;
        if (binary && kind < 50)
            b.yr = 8'($urandom_range(0, 255));
        else
            b.yr = encode($urandom_range(0, 99), binary);
        if (kind < 30)
            b.dt = encode($urandom_range(27, 31), binary);
        b.hr = encode($urandom_range(0, 23), binary);
        b.mi = encode($urandom_range(0, 59), binary);
        b.se = encode($urandom_range(0, 59), binary);
        return b;
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        {year_raw, month_raw, date_raw, hour_raw, minute_raw, second_raw} <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // BCD after reset
        send_item({8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00});
        send_item({8'h99, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00});
        send_item({8'h24, 8'h01, 8'h00, 8'h12, 8'h00, 8'h00});
        send_item({8'h24, 8'h01, 8'h32, 8'h12, 8'h00, 8'h00});
        send_item({8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
        send_item({8'h69, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
        send_item({8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
        send_item({8'h00, 8'h02, 8'h29, 8'h01, 8'h02, 8'h03});
        send_item({8'h00, 8'h03, 8'h01, 8'h01, 8'h02, 8'h03});
        send_item({8'h24, 8'h04, 8'h31, 8'h00, 8'h00, 8'h00});
        send_item({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_item({8'hAF, 8'h0C, 8'h1F, 8'hFF, 8'hFF, 8'hFF});
        settle();

        write_mode(1'b1);
        send_item({8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0});
        send_item({8'd69, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59});
        send_item({8'd70, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0});
        send_item({8'd200, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0});
        send_item({8'd200, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0});
        send_item({8'd255, 8'd12, 8'd31, 8'd255, 8'd255, 8'd255});
        send_item({8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0});
        send_item({8'd1, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0});
        send_item({8'd1, 8'd1, 8'd32, 8'd0, 8'd0, 8'd0});
        send_item({8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0});
        send_item({8'd96, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0});

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_mode(phase_mode[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                pause_sender(phase_pct[p]);
                send_item(random_item(phase_mode[p]));
            end
        end
        settle();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
sv/rtfus_pkg.sv
sv/rtfus_decode.sv
sv/rtfus_date.sv
sv/rtfus_secs.sv
sv/rtc_fields_to_unix_seconds_top.sv
sv/rtfus_checker.sv
verif/tb_rtc_fields_to_unix_seconds_top.sv
